// ===== hdl/fra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fragment reassembler package
// Shared sizes, codes and the item, result and store request types.
// ----------------------------------------------------------------------------
package fra_pkg;

	// Byte store size and derived widths
	localparam int STORE_BYTES = 4096;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int LEN_W       = 13;
	localparam int HDR_BYTES   = 3;
	localparam int ELAPSED_W   = 17;
	localparam int TIMEOUT_W   = 16;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5000;

	// Kind of an input item
	typedef enum logic [1:0] {
		MODE_BYTE  = 2'd0,
		MODE_TICK  = 2'd1,
		MODE_DRAIN = 2'd2
	} mode_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_NONE        = 3'd0,
		ST_NOT_HANDLED = 3'd1,
		ST_DUPLICATE   = 3'd2,
		ST_OUT_OF_ORD  = 3'd3,
		ST_OVERFLOW    = 3'd4,
		ST_STORED      = 3'd5,
		ST_COMPLETE    = 3'd6,
		ST_TIMEOUT     = 3'd7
	} status_t;

	// One input item
	typedef struct packed {
		mode_t      mode;
		logic [7:0] data_byte;
		logic       eop;
		logic       known;
	} item_t;

	// One result item, less the store read data
	typedef struct packed {
		status_t          status;
		logic             handled;
		logic [LEN_W-1:0] msg_len;
		logic             rd_valid;
		logic             rd_last;
	} result_t;

	// Store access for one item
	typedef struct packed {
		logic              en;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
	} ram_req_t;

endpackage

// ===== hdl/fra_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access a cycle, write or read, with the read data registered.
// ----------------------------------------------------------------------------
module fra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read data only changes on a read, so it holds across stalls.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== hdl/fra_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fragment reassembler core
// Reassembly state and the per-item update: header capture, tentative store
// writes, packet judgement, timer and drain.
// ----------------------------------------------------------------------------
module fra_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               fire,
	input  fra_pkg::item_t                     item,
	input  logic [fra_pkg::TIMEOUT_W-1:0]      timeout,
	output fra_pkg::result_t                   res,
	output fra_pkg::ram_req_t                  ram_req
);

	localparam int EXT_W = fra_pkg::LEN_W + 1;
	localparam logic [EXT_W-1:0] STORE_EXT = EXT_W'(fra_pkg::STORE_BYTES);
	localparam logic [fra_pkg::ELAPSED_W-1:0] ELAPSED_MAX = '1;
	localparam logic [7:0] HDR_COUNT = 8'(fra_pkg::HDR_BYTES);
	localparam logic [7:0] CNT_MAX   = 8'd255;

	// Reserved first bytes
	localparam logic [7:0] SIG_A = 8'h91;
	localparam logic [7:0] SIG_B = 8'h81;
	localparam logic [7:0] SIG_C = 8'h80;
	localparam logic [7:0] SIG_D = 8'h57;

	typedef logic [7:0] hdr_t [fra_pkg::HDR_BYTES];

	// Header is usable when the first byte is not reserved and index < total.
	function automatic logic hdr_ok(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2);
		logic reserved;
		reserved = (b0 == SIG_A) || (b0 == SIG_B) || (b0 == SIG_C) || (b0 == SIG_D);
		return !reserved && (b2 != 8'd0) && (b1 < b2);
	endfunction

	logic [7:0]                   cur_id_q, done_id_q, frags_q, cnt_q;
	logic [fra_pkg::LEN_W-1:0]    alen_q, ready_q, rptr_q;
	logic                         run_q;
	logic [fra_pkg::ELAPSED_W-1:0] elapsed_q;
	hdr_t                         hdr_q;

	logic [7:0]                   cur_id_n, done_id_n, frags_n, cnt_n;
	logic [fra_pkg::LEN_W-1:0]    alen_n, ready_n, rptr_n;
	logic                         run_n;
	logic [fra_pkg::ELAPSED_W-1:0] elapsed_n;
	hdr_t                         hdr_n;

	logic                         abort;
	logic                         fresh_w, fresh_e;
	logic [EXT_W-1:0]             wr_addr, new_size;
	logic [fra_pkg::LEN_W-1:0]    alen_eff, rptr_inc;
	logic [7:0]                   frags_eff, frags_inc, payload;
	logic [fra_pkg::ELAPSED_W-1:0] elapsed_inc;

	// Per-item next state and result
	always_comb begin
		cur_id_n    = cur_id_q;
		done_id_n   = done_id_q;
		frags_n     = frags_q;
		cnt_n       = cnt_q;
		alen_n      = alen_q;
		ready_n     = ready_q;
		rptr_n      = rptr_q;
		run_n       = run_q;
		elapsed_n   = elapsed_q;
		hdr_n       = hdr_q;
		abort       = 1'b0;
		res         = '0;
		ram_req     = '0;
		fresh_w     = (hdr_q[0] != cur_id_q);
		fresh_e     = 1'b0;
		wr_addr     = '0;
		new_size    = '0;
		alen_eff    = '0;
		frags_eff   = '0;
		frags_inc   = '0;
		payload     = '0;
		elapsed_inc = '0;
		rptr_inc    = '0;

		case (item.mode)
			fra_pkg::MODE_BYTE: begin
				// Header capture or tentative payload write
				if (cnt_q != CNT_MAX) begin
					if (cnt_q < HDR_COUNT) begin
						hdr_n[cnt_q[1:0]] = item.data_byte;
					end else if (hdr_ok(hdr_q[0], hdr_q[1], hdr_q[2]) &&
							hdr_q[0] != done_id_q &&
							hdr_q[1] == (fresh_w ? 8'd0 : frags_q)) begin
						wr_addr = EXT_W'(fresh_w ? '0 : alen_q) +
							EXT_W'(cnt_q - HDR_COUNT);
						if (wr_addr < STORE_EXT) begin
							ram_req.en    = 1'b1;
							ram_req.we    = 1'b1;
							ram_req.addr  = wr_addr[fra_pkg::ADDR_W-1:0];
							ram_req.wdata = item.data_byte;
							ready_n       = '0;
							rptr_n        = '0;
						end
					end
					cnt_n = cnt_q + 8'd1;
				end

				// Judgement at the end of the packet
				if (item.eop) begin
					if (!item.known || cnt_n < HDR_COUNT ||
							!hdr_ok(hdr_n[0], hdr_n[1], hdr_n[2])) begin
						res.status = fra_pkg::ST_NOT_HANDLED;
					end else if (hdr_n[0] == done_id_q) begin
						if (hdr_n[0] == cur_id_q && frags_q != 8'd0) begin
							abort = 1'b1;
						end
						res.status = fra_pkg::ST_DUPLICATE;
					end else begin
						fresh_e   = (hdr_n[0] != cur_id_q);
						frags_eff = fresh_e ? 8'd0 : frags_q;
						alen_eff  = fresh_e ? '0 : alen_q;
						if (fresh_e) begin
							cur_id_n  = hdr_n[0];
							run_n     = 1'b1;
							elapsed_n = '0;
							frags_n   = '0;
							alen_n    = '0;
						end
						payload  = cnt_n - HDR_COUNT;
						new_size = EXT_W'(alen_eff) + EXT_W'(payload);
						frags_inc = frags_eff + 8'd1;
						if (hdr_n[1] != frags_eff) begin
							abort      = 1'b1;
							res.status = fra_pkg::ST_OUT_OF_ORD;
						end else if (new_size > STORE_EXT) begin
							abort      = 1'b1;
							res.status = fra_pkg::ST_OVERFLOW;
						end else if (frags_inc >= hdr_n[2]) begin
							done_id_n   = hdr_n[0];
							ready_n     = new_size[fra_pkg::LEN_W-1:0];
							rptr_n      = '0;
							res.msg_len = new_size[fra_pkg::LEN_W-1:0];
							abort       = 1'b1;
							res.status  = fra_pkg::ST_COMPLETE;
						end else begin
							alen_n     = new_size[fra_pkg::LEN_W-1:0];
							frags_n    = frags_inc;
							res.status = fra_pkg::ST_STORED;
						end
					end
					res.handled = (res.status >= fra_pkg::ST_DUPLICATE) &&
						(res.status <= fra_pkg::ST_COMPLETE);
					cnt_n = '0;
				end
			end

			fra_pkg::MODE_TICK: begin
				// Saturating tick count against the timeout
				if (run_q && frags_q != 8'd0) begin
					elapsed_inc = (elapsed_q != ELAPSED_MAX) ?
						elapsed_q + 1'b1 : elapsed_q;
					if (elapsed_inc > fra_pkg::ELAPSED_W'(timeout)) begin
						abort      = 1'b1;
						res.status = fra_pkg::ST_TIMEOUT;
					end else begin
						elapsed_n = elapsed_inc;
					end
				end
			end

			fra_pkg::MODE_DRAIN: begin
				// Read the next message byte from the store
				if (rptr_q < ready_q &&
						EXT_W'(rptr_q) < STORE_EXT) begin
					ram_req.en   = 1'b1;
					ram_req.addr = rptr_q[fra_pkg::ADDR_W-1:0];
					res.rd_valid = 1'b1;
					rptr_inc     = rptr_q + 1'b1;
					if (rptr_inc >= ready_q) begin
						res.rd_last = 1'b1;
						ready_n     = '0;
						rptr_n      = '0;
					end else begin
						rptr_n = rptr_inc;
					end
				end
			end

			default: begin
			end
		endcase

		// Abort of a partial message overrides the updates above.
		if (abort) begin
			frags_n   = '0;
			alen_n    = '0;
			run_n     = 1'b0;
			elapsed_n = '0;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_id_q  <= '0;
			done_id_q <= '0;
			frags_q   <= '0;
			cnt_q     <= '0;
			alen_q    <= '0;
			ready_q   <= '0;
			rptr_q    <= '0;
			run_q     <= 1'b0;
			elapsed_q <= '0;
			hdr_q     <= '{default: 8'd0};
		end else if (fire) begin
			cur_id_q  <= cur_id_n;
			done_id_q <= done_id_n;
			frags_q   <= frags_n;
			cnt_q     <= cnt_n;
			alen_q    <= alen_n;
			ready_q   <= ready_n;
			rptr_q    <= rptr_n;
			run_q     <= run_n;
			elapsed_q <= elapsed_n;
			hdr_q     <= hdr_n;
		end
	end

endmodule

// ===== hdl/fragment_reassembler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fragment reassembler unit
// Reassembles fragmented messages from packet bytes into a byte store and
// reads completed messages back out on request.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel carries one item per handshake: a packet byte, a timer
// tick or a drain request, chosen by the mode in tuser. tlast marks the last
// byte of a packet, when the packet is judged. The master channel returns one
// result item for every input item, in order.
// An item is accepted into the input register, processed by the core once
// the result register can advance, and lands in the result register, from
// which it is offered to the receiver. One item is taken per cycle while the
// receiver takes results; the rate is set by the single store port, which
// takes one write or one read per item.
// When the receiver stalls, an empty input register still takes one more
// item; once both registers hold an item, tready follows the receiver's
// tready in the same cycle.
// Reset clears all reassembly state, id 0 then counts as completed, and the
// timeout returns to 5000 ticks. The store has no clearing pass: only
// written bytes are ever read. The user writes the timeout register over
// the cfg channel only while the unit is idle; the block does not check it.
// ----------------------------------------------------------------------------
module fragment_reassembler_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: timeout_ticks
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	// Input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tlast,  // end_of_packet
	input  logic [2:0]  s_tuser,  // [1:0] mode, [2] sender_known
	// Result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [0] handled, [13:1] message_length,
	                              // [21:14] read_byte, [23:22] zero
	output logic        m_tlast,  // read_last
	output logic [3:0]  m_tuser   // [2:0] status, [3] read_valid
);

	logic                          valid_s1, valid_s2;
	fra_pkg::item_t                item_s1;
	fra_pkg::result_t              res_s2, res;
	fra_pkg::ram_req_t             ram_req;
	logic [fra_pkg::TIMEOUT_W-1:0] timeout_q;
	logic [7:0]                    ram_rdata;
	logic                          adv, fire;

	// Pipeline control
	assign adv      = !valid_s2 || m_tready;
	assign fire     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	// Timeout register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= fra_pkg::TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.mode      <= fra_pkg::mode_t'(s_tuser[1:0]);
			item_s1.known     <= s_tuser[2];
			item_s1.data_byte <= s_tdata;
			item_s1.eop       <= s_tlast;
		end
	end

	fra_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (item_s1),
		.timeout (timeout_q),
		.res     (res),
		.ram_req (ram_req)
	);

	fra_ram #(
		.WIDTH (8),
		.DEPTH (fra_pkg::STORE_BYTES)
	) u_store (
		.clk   (clk),
		.en    (fire && ram_req.en),
		.we    (ram_req.we),
		.addr  (ram_req.addr),
		.wdata (ram_req.wdata),
		.rdata (ram_rdata)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	// Result packing; store data shows only on a drained byte.
	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, (res_s2.rd_valid ? ram_rdata : 8'd0),
		res_s2.msg_len, res_s2.handled};
	assign m_tlast  = res_s2.rd_last;
	assign m_tuser  = {res_s2.rd_valid, res_s2.status};

	// A drained byte carries no packet status.
	a_read_no_status : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3] |-> m_tuser[2:0] == fra_pkg::ST_NONE && !m_tdata[0])
		else $error("read byte with packet status");

	// The last-byte mark only comes with a valid byte.
	a_last_has_byte : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[3])
		else $error("read_last without read_valid");

	// Handled follows the status code.
	a_handled_status : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[0] == (m_tuser[2:0] >= fra_pkg::ST_DUPLICATE &&
			m_tuser[2:0] <= fra_pkg::ST_COMPLETE))
		else $error("handled does not match status");

	// A length is only reported with a completed message.
	a_len_complete : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[13:1] != '0 |-> m_tuser[2:0] == fra_pkg::ST_COMPLETE)
		else $error("message length without completion");

	// An empty input register always takes an item.
	a_ready_empty : assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with empty input register");

endmodule
